@@ sv/hgc_pkg.sv @@
`default_nettype none
package hgc_pkg;
    localparam int MaxStops = 4;
    localparam int StopRegs = 4;
    localparam int FracBits = 12;
    localparam int QDepth = 2;
    localparam logic [16:0] TOne = 17'd4096;

    localparam logic [2:0] RegStopCount = 3'd0;
    localparam logic [2:0] RegStop0 = 3'd1;
    localparam logic [2:0] RegStopLast = 3'd4;

    localparam logic [2:0] ResetCount = 3'd4;
    localparam logic [47:0] ResetStop0 = 48'd2526451455;
    localparam logic [47:0] ResetStop1 = 48'd1765231506175;
    localparam logic [47:0] ResetStop2 = 48'd3521867219199;
    localparam logic [47:0] ResetStop3 = 48'd5282793655039;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic        black;
        logic        interp;
        logic        equal;
        logic [16:0] num;
        logic [15:0] den;
        logic [31:0] lo_color;
        logic [31:0] hi_color;
    } t_job;
endpackage
`default_nettype wire

@@ sv/hgc_front.sv @@
`default_nettype none
module hgc_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic [15:0]     i_heat_value,
    input  wire logic [2:0]      i_count,
    input  wire logic [47:0]     i_stop [hgc_pkg::StopRegs],
    output logic                 o_valid,
    input  wire logic            i_stall,
    output hgc_pkg::t_job        o_job
);
    hgc_pkg::t_job r_q [hgc_pkg::QDepth];
    logic r_wp, r_rp;
    logic [1:0] r_fill;
    hgc_pkg::t_job n_job;
    logic [2:0] w_n;
    logic w_found;
    logic w_push, w_pop;

    always_comb begin
        w_n = (i_count > 3'(hgc_pkg::MaxStops)) ? 3'(hgc_pkg::MaxStops) : i_count;
        n_job = '0;
        w_found = 1'b0;
        for (int i = 0; i < hgc_pkg::StopRegs - 1; i++) begin
            if (!w_found && (3'(i + 1) < w_n) &&
                i_heat_value >= i_stop[i][47:32] && i_heat_value <= i_stop[i+1][47:32]) begin
                w_found = 1'b1;
                n_job.interp = 1'b1;
                n_job.equal = (i_stop[i][47:32] == i_stop[i+1][47:32]);
                n_job.num = 17'(i_heat_value - i_stop[i][47:32]);
                n_job.den = i_stop[i+1][47:32] - i_stop[i][47:32];
                n_job.lo_color = i_stop[i][31:0];
                n_job.hi_color = i_stop[i+1][31:0];
            end
        end
        if (w_n == 3'd0) begin
            n_job.black = 1'b1;
        end else if (!w_found) begin
            n_job.lo_color = i_stop[2'(w_n - 3'd1)][31:0];
        end
    end

    assign o_stall = (r_fill == 2'(hgc_pkg::QDepth));
    assign w_push = i_valid && !o_stall;
    assign o_valid = (r_fill != 2'd0);
    assign w_pop = o_valid && !i_stall;
    assign o_job = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_fill <= r_fill + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= n_job;
    end

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 2'(hgc_pkg::QDepth)) else $error("queue overfill");
    a_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == 2'd0 || r_fill == 2'd2) |-> r_wp == r_rp) else $error("pointer slip");
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_fill == $past(r_fill) + 2'd1) else $error("fill count");
endmodule
`default_nettype wire

@@ sv/hgc_back.sv @@
`default_nettype none
module hgc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire hgc_pkg::t_job i_job,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue,
    output logic [7:0]         o_alpha,
    output logic               o_interpolated
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001, S_DIV = 3'b010, S_OUT = 3'b100
    } t_state;
    t_state r_state;
    hgc_pkg::t_job r_job;
    logic [28:0] r_rem;
    logic [12:0] r_quo;
    logic [4:0] r_cnt;
    logic w_bit;
    logic [29:0] w_trial;
    logic [16:0] w_t;
    logic [7:0] w_ch [4];

    function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                         input logic [16:0] t);
        logic signed [8:0] d;
        logic signed [26:0] p;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = 27'(d) * $signed({10'd0, t});
        return a + 8'(p >>> hgc_pkg::FracBits);
    endfunction

    // Restoring division, one quotient bit a cycle: (num << 12) / den.
    // Dividend bits are num followed by 12 zeros, MSB first.
    assign w_bit = (r_cnt >= 5'd12) ? r_job.num[5'(r_cnt - 5'd12)] : 1'b0;
    assign w_trial = {r_rem, w_bit} - {14'd0, r_job.den};
    assign w_t = (r_job.equal || !r_job.interp) ? 17'd0 :
                 ((r_quo > 13'd4096) ? hgc_pkg::TOne : 17'(r_quo));
    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) r_state <= S_DIV;
                S_DIV: if (r_cnt == 5'd0) r_state <= S_OUT;
                S_OUT: if (!i_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_job <= i_job;
            r_rem <= 29'd0;
            r_quo <= 13'd0;
            r_cnt <= 5'd28;
        end else if (r_state == S_DIV) begin
            if (!w_trial[29]) begin
                r_rem <= w_trial[28:0];
                r_quo <= {r_quo[11:0], 1'b1};
            end else begin
                r_rem <= {r_rem[27:0], w_bit};
                r_quo <= {r_quo[11:0], 1'b0};
            end
            if (r_cnt != 5'd0) r_cnt <= r_cnt - 5'd1;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_ch[k] = r_job.black ? 8'd0 :
                blend(r_job.lo_color[k*8 +: 8], r_job.hi_color[k*8 +: 8], w_t);
        end
    end

    assign o_valid = (r_state == S_OUT);
    assign o_red = w_ch[3];
    assign o_green = w_ch[2];
    assign o_blue = w_ch[1];
    assign o_alpha = w_ch[0];
    assign o_interpolated = r_job.interp;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_red)) else $error("result lost");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("bad state");
    a_blk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_job.black) |-> !o_interpolated) else $error("black interp");
endmodule
`default_nettype wire

@@ sv/heat_gradient_colorizer.sv @@
`default_nettype none
// Heat value colorizer: maps an unsigned Q4.12 heat value to an RGBA8 color
// through up to four gradient stops set over the APB port (stop_count at 0x0,
// stop words at 0x8..0x20, 64-bit data). The front classifies an item
// combinationally into a two-beat queue; the back runs a 29-step bit-serial
// divider for the blend fraction and takes a new beat only once idle again.
module heat_gradient_colorizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_heat_value,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [7:0]       o_alpha,
    output logic             o_interpolated,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    logic [2:0] r_count;
    logic [47:0] r_stop [hgc_pkg::StopRegs];
    logic [2:0] w_idx;
    logic w_qv, w_qs;
    hgc_pkg::t_job w_job;

    assign pready = 1'b1;
    assign w_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= hgc_pkg::ResetCount;
            r_stop[0] <= hgc_pkg::ResetStop0;
            r_stop[1] <= hgc_pkg::ResetStop1;
            r_stop[2] <= hgc_pkg::ResetStop2;
            r_stop[3] <= hgc_pkg::ResetStop3;
        end else if (psel && penable && pwrite) begin
            if (w_idx == hgc_pkg::RegStopCount) r_count <= pwdata[2:0];
            else if (w_idx <= hgc_pkg::RegStopLast)
                r_stop[2'(w_idx - hgc_pkg::RegStop0)] <= pwdata[47:0];
        end
    end

    always_comb begin
        prdata = 64'd0;
        if (w_idx == hgc_pkg::RegStopCount) prdata = {61'd0, r_count};
        else if (w_idx <= hgc_pkg::RegStopLast)
            prdata = {16'd0, r_stop[2'(w_idx - hgc_pkg::RegStop0)]};
    end

    hgc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_heat_value,
        .i_count(r_count), .i_stop(r_stop),
        .o_valid(w_qv), .i_stall(w_qs), .o_job(w_job)
    );

    hgc_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_stall(w_qs), .i_job(w_job),
        .o_valid, .i_stall, .o_red, .o_green, .o_blue, .o_alpha, .o_interpolated
    );
endmodule
`default_nettype wire

@@ sim/heat_gradient_colorizer_checker.sv @@
`timescale 1ns / 100ps
module heat_gradient_colorizer_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        o_stall,
    input  wire logic [15:0] i_heat_value,
    input  wire logic        o_valid,
    input  wire logic        i_stall,
    input  wire logic [7:0]  o_red,
    input  wire logic [7:0]  o_green,
    input  wire logic [7:0]  o_blue,
    input  wire logic [7:0]  o_alpha,
    input  wire logic        o_interpolated,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    input  wire logic        pready,
    output int               o_errors,
    output int               o_pending
);
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       interp;
    } t_heat_color;

    logic [2:0]  stop_cnt;
    logic [47:0] stop_w [hgc_pkg::StopRegs];
    t_heat_color colors_due [$];

    // Signed product shifted arithmetically, so negative deltas round down.
    function automatic logic [7:0] mix_channel(logic [7:0] a, logic [7:0] b, int t);
        int prod;
        prod = (int'(b) - int'(a)) * t;
        return 8'(int'(a) + (prod >>> hgc_pkg::FracBits));
    endfunction

    function automatic t_heat_color colorize(logic [15:0] v);
        t_heat_color c;
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        int unsigned t;
        logic [47:0] wl;
        logic [47:0] wh;
        c = '0;
        n = (stop_cnt > hgc_pkg::MaxStops) ? hgc_pkg::MaxStops : stop_cnt;
        if (n == 0) return c;
        for (int i = 0; i + 1 < n; i++) begin
            wl = stop_w[i];
            wh = stop_w[i + 1];
            lo = wl[47:32];
            hi = wh[47:32];
            if (v >= lo && v <= hi) begin
                t = 0;
                if (hi != lo) begin
                    t = ((v - lo) << hgc_pkg::FracBits) / (hi - lo);
                    if (t > hgc_pkg::TOne) t = hgc_pkg::TOne;
                end
                c.red = mix_channel(wl[31:24], wh[31:24], t);
                c.green = mix_channel(wl[23:16], wh[23:16], t);
                c.blue = mix_channel(wl[15:8], wh[15:8], t);
                c.alpha = mix_channel(wl[7:0], wh[7:0], t);
                c.interp = 1'b1;
                return c;
            end
        end
        wl = stop_w[n - 1];
        c.red = wl[31:24];
        c.green = wl[23:16];
        c.blue = wl[15:8];
        c.alpha = wl[7:0];
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_heat_color got;
        t_heat_color want;
        if (!i_rst_n) begin
            stop_cnt <= hgc_pkg::ResetCount;
            stop_w[0] <= hgc_pkg::ResetStop0;
            stop_w[1] <= hgc_pkg::ResetStop1;
            stop_w[2] <= hgc_pkg::ResetStop2;
            stop_w[3] <= hgc_pkg::ResetStop3;
            colors_due.delete();
            o_errors <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[2:0] == 3'd0) begin
                if (paddr[5:3] == hgc_pkg::RegStopCount)
                    stop_cnt <= pwdata[2:0];
                else if (paddr[5:3] >= hgc_pkg::RegStop0 &&
                         paddr[5:3] <= hgc_pkg::RegStopLast)
                    stop_w[paddr[5:3] - hgc_pkg::RegStop0] <= pwdata[47:0];
            end
            if (i_valid && !o_stall)
                colors_due.push_back(colorize(i_heat_value));
            if (o_valid && !i_stall) begin
                got = '{o_red, o_green, o_blue, o_alpha, o_interpolated};
                if (colors_due.size() == 0) begin
                    $display("%0t: result beat with nothing expected: %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = colors_due.pop_front();
                    if (got !== want) begin
                        $display({"%0t: rgba/interp expected %0d %0d %0d %0d %0d,",
                                  " got %0d %0d %0d %0d %0d"},
                                 $time, want.red, want.green, want.blue, want.alpha,
                                 want.interp, got.red, got.green, got.blue, got.alpha,
                                 got.interp);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

    assign o_pending = colors_due.size();
endmodule

@@ sim/heat_gradient_colorizer_tb.sv @@
`timescale 1ns / 100ps
module heat_gradient_colorizer_tb;
    localparam int CycleLimit = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_heat_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_red, o_green, o_blue, o_alpha;
    logic        o_interpolated;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    int          errors;
    int          pending;
    int          cycles = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;
    logic [15:0] lvl [hgc_pkg::StopRegs];

    always #5 i_clk = ~i_clk;

    heat_gradient_colorizer dut (.*);

    heat_gradient_colorizer_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_heat_value, .o_valid, .i_stall,
        .o_red, .o_green, .o_blue, .o_alpha, .o_interpolated,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic reg_write(int idx, logic [63:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 6'(8 * idx);
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic send_heat(logic [15:0] v);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_heat_value <= v;
        do @(posedge i_clk); while (o_stall);
    endtask

    function automatic logic [63:0] stop_word(logic [15:0] level);
        return {$urandom(), 16'(level), 32'($urandom())};
    endfunction

    // Sink side: a random stall per beat, plus one long hold on request.
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            hold = quiet ? 0 : $urandom_range(0, 15);
            if (hold_req) begin
                hold = 300;
                hold_req = 1'b0;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        int cnt;
        logic [15:0] lo_l;
        logic [15:0] hi_l;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset gradient: stop levels, between them, past the last, extremes.
        foreach (lvl[i]) lvl[i] = '0;
        send_heat(16'd0);
        send_heat(16'd409);
        send_heat(16'd410);
        send_heat(16'd411);
        send_heat(16'd819);
        send_heat(16'd1229);
        send_heat(16'd1230);
        send_heat(16'hFFFF);
        drain();

        reg_write(hgc_pkg::RegStopCount, 64'd0);
        send_heat(16'd500);
        send_heat(16'hFFFF);
        drain();
        reg_write(hgc_pkg::RegStopCount, 64'd1);
        send_heat(16'd0);
        drain();
        // Equal levels, a descending pair, and full-swing colors at the ends.
        reg_write(hgc_pkg::RegStopCount, 64'd7);
        reg_write(hgc_pkg::RegStop0, {16'hFFFF, 16'h0000, 32'h00FF00FF});
        reg_write(hgc_pkg::RegStop0 + 1, {16'hFFFF, 16'hFFFF, 32'hFF00FF00});
        reg_write(hgc_pkg::RegStop0 + 2, {16'hFFFF, 16'h0000, 32'h00000000});
        reg_write(hgc_pkg::RegStopLast, {16'hFFFF, 16'hFFFF, 32'hFFFFFFFF});
        reg_write(hgc_pkg::RegStopLast + 1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_heat(16'h0000);
        send_heat(16'hFFFF);
        drain();
        reg_write(hgc_pkg::RegStop0, {16'h0, 16'h0000, 32'h00FF00FF});
        reg_write(hgc_pkg::RegStop0 + 1, {16'h0, 16'h0000, 32'h00FF00FF});
        reg_write(hgc_pkg::RegStop0 + 2, {16'h0, 16'hFFFF, 32'hFF00FF00});
        send_heat(16'h0000);
        send_heat(16'h8000);
        send_heat(16'hFFFF);
        send_heat(16'h7FFF);
        drain();

        for (int phase = 0; phase < 13; phase++) begin
            cnt = (phase % 4 == 0) ? $urandom_range(0, 7) : $urandom_range(2, 4);
            for (int i = 0; i < hgc_pkg::StopRegs; i++) begin
                lvl[i] = (i == 0) ? 16'($urandom_range(0, 4000)) :
                         16'(lvl[i - 1] + $urandom_range(0, 20000));
                if (lvl[i] < lvl[(i == 0) ? 0 : i - 1]) lvl[i] = 16'hFFFF;
            end
            if (phase == 5) lvl[2] = lvl[1] - 16'd1;
            if (phase == 6) lvl[1] = lvl[0];
            reg_write(hgc_pkg::RegStopCount, 64'(cnt));
            for (int i = 0; i < hgc_pkg::StopRegs; i++)
                reg_write(hgc_pkg::RegStop0 + i, stop_word(lvl[i]));
            quiet = (phase % 3 == 1);
            if (phase == 2) hold_req = 1'b1;
            lo_l = lvl[0];
            hi_l = lvl[3];
            for (int k = 0; k < 125; k++) begin
                case ($urandom_range(0, 9))
                    0, 1:    send_heat(16'($urandom()));
                    2:       send_heat(lvl[$urandom_range(0, 3)]);
                    default: send_heat(16'($urandom_range(lo_l, hi_l)));
                endcase
            end
            drain();
        end

        quiet = 1'b0;
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
